>>> sv/assert_macros.svh
// Assertion macros shared by the RTL modules; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed")
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed")
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> sv/grs_pkg.sv
// Shared constants and controller/datapath interface types for group_reverse_stream.
package grs_pkg;

   localparam int MAX_GROUP = 16;
   localparam int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int CNT_W     = $clog2(MAX_GROUP + 1);
   localparam int VAL_W     = 32;
   localparam int CFG_W     = 5;

   // controller -> datapath
   typedef struct packed {
      logic load;    // accept beat, store value, group stays open
      logic start;   // accept beat, store value, close group and set up readout
      logic read;    // issue one store read and advance the read pointer
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic emit;    // the offered beat closes the group
      logic done;    // every read of the group has been issued
   } status_type;

endpackage

>>> sv/grs_ram.sv
// Generic single write port RAM with registered read data.
module grs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/grs_datapath.sv
// Datapath: group store, fill and read counters, group size register.
`include "assert_macros.svh"
module grs_datapath import grs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic                    csr_we,
   input  logic [CFG_W-1:0]        csr_group_size,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic                    req_end_of_sequence,
   output logic signed [VAL_W-1:0] rsp_value_out,
   output logic                    rsp_last_out
);

   logic [CFG_W-1:0] size_ff;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             rev_ff, rev_in;
   logic             eos_ff, eos_in;

   logic [CNT_W-1:0] size_eff;
   logic [CNT_W-1:0] count_next;
   logic             full;
   logic [VAL_W-1:0] rdata;

   // size 0 acts as 1, sizes above the store depth saturate
   always_comb begin
      if (size_ff == '0) begin
         size_eff = CNT_W'(1);
      end else if (int'(size_ff) > MAX_GROUP) begin
         size_eff = CNT_W'(MAX_GROUP);
      end else begin
         size_eff = CNT_W'(size_ff);
      end
   end

   assign count_next = fill_ff + CNT_W'(1);
   assign full       = (count_next >= size_eff);

   assign status.emit = full | req_end_of_sequence;
   assign status.done = (left_ff == '0);

   always_comb begin
      fill_in   = fill_ff;
      left_in   = left_ff;
      rd_ptr_in = rd_ptr_ff;
      rev_in    = rev_ff;
      eos_in    = eos_ff;
      if (cmd.load) begin
         fill_in = count_next;
      end
      if (cmd.start) begin
         fill_in   = '0;
         left_in   = count_next;
         rev_in    = full;
         eos_in    = req_end_of_sequence;
         // reversed readout starts at the newest entry
         rd_ptr_in = full ? fill_ff[IDX_W-1:0] : '0;
      end
      if (cmd.read) begin
         left_in   = left_ff - CNT_W'(1);
         rd_ptr_in = rev_ff ? rd_ptr_ff - IDX_W'(1) : rd_ptr_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= CFG_W'(1);
         fill_ff <= '0;
         left_ff <= '0;
      end else begin
         if (csr_we) begin
            size_ff <= csr_group_size;
         end
         fill_ff <= fill_in;
         left_ff <= left_in;
      end
      rd_ptr_ff <= rd_ptr_in;
      rev_ff    <= rev_in;
      eos_ff    <= eos_in;
   end

   grs_ram #(
      .WIDTH (VAL_W),
      .DEPTH (MAX_GROUP)
   ) u_store (
      .clock (clock),
      .we    (cmd.load | cmd.start),
      .waddr (fill_ff[IDX_W-1:0]),
      .wdata (req_value),
      .re    (cmd.read),
      .raddr (rd_ptr_ff),
      .rdata (rdata)
   );

   assign rsp_value_out = rdata;
   assign rsp_last_out  = eos_ff & status.done;

   `ASSERT_ALWAYS(a_fill_in_range, int'(fill_ff) < MAX_GROUP);
   `ASSERT_ALWAYS(a_read_has_work, !cmd.read || (left_ff != '0));

endmodule

>>> sv/grs_controller.sv
// Controller: accepts beats, then steps the readout of a closed group.
`include "assert_macros.svh"
module grs_controller import grs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_FILL,
      S_READ,
      S_SHOW
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      case (state_ff)
         S_FILL: begin
            if (req_valid) begin
               if (status.emit) begin
                  cmd.start    = 1'b1;
                  state_in     = S_READ;
                  req_ready_in = 1'b0;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_READ: begin
            cmd.read     = 1'b1;
            state_in     = S_SHOW;
            rsp_valid_in = 1'b1;
         end
         S_SHOW: begin
            if (rsp_ready) begin
               if (status.done) begin
                  state_in     = S_FILL;
                  rsp_valid_in = 1'b0;
                  req_ready_in = 1'b1;
               end else begin
                  // next read lands in the output register as this beat leaves
                  cmd.read = 1'b1;
               end
            end
         end
         default: begin
            state_in     = S_FILL;
            req_ready_in = 1'b1;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_ALWAYS(a_one_side_open, !(req_ready_ff && rsp_valid_ff));
   `ASSERT_NEXT(a_start_reads, cmd.start, cmd.read);

endmodule

>>> sv/group_reverse_stream.sv
// group_reverse_stream: reverses a stream of values in groups of a configured size.
//
// Input beats (req_value, req_end_of_sequence) are taken on req_valid & req_ready.
// Values collect in a 16-entry group store. When the group reaches the size in
// the csr register it is sent out newest first; an end-of-sequence beat that
// closes a shorter group sends it out in arrival order. The last beat of a
// sequence carries rsp_last_out. csr beats are always taken and should be sent
// only while no group is being read out; size 0 acts as 1, larger than 16 as 16.
// Timing: a beat that leaves the group open is stored, and the next beat can follow
// straight after. A beat that closes a group of n values is followed by the first
// store read, then n result beats at one per cycle while rsp_ready is high;
// req_ready is low from the closing beat until the last result beat is taken. The
// single read port of the group store sets the one result per cycle readout.
// A stalled receiver holds the current result beat; readout resumes on rsp_ready.
// Reset (synchronous) empties the group and sets the group size to 1.
module group_reverse_stream import grs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CFG_W-1:0]        csr_group_size,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic                    req_end_of_sequence,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_value_out,
   output logic                    rsp_last_out
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   grs_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   grs_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_we              (csr_valid & csr_ready),
      .csr_group_size      (csr_group_size),
      .req_value           (req_value),
      .req_end_of_sequence (req_end_of_sequence),
      .rsp_value_out       (rsp_value_out),
      .rsp_last_out        (rsp_last_out)
   );

endmodule
